### rtl/core/eai_pkg.sv
// ----------------------------------------------------------------------------
// eai_pkg
// Shared types, sizes and codes of the elite archive insert block.
// ----------------------------------------------------------------------------
package eai_pkg;

	localparam int NICHES    = 64;
	localparam int NICHE_W   = $clog2(NICHES);
	localparam int DIVC_W    = $clog2(NICHE_W + 1);
	localparam int DATA_W    = 32;
	localparam int OUT_IDX_W = 6;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_BOUND  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BOUND = 1'b1;

	localparam logic signed [DATA_W-1:0] LOW_BOUND_RST  = 32'sd0;
	localparam logic signed [DATA_W-1:0] HIGH_BOUND_RST = 32'sd65536;

	typedef struct packed {
		logic signed [DATA_W-1:0] cand_value;
		logic signed [DATA_W-1:0] cand_score;
	} in_item_t;

	typedef struct packed {
		logic                     accepted;
		logic [OUT_IDX_W-1:0]     niche_index;
		logic [DATA_W-1:0]        offers_seen;
		logic [DATA_W-1:0]        offers_rejected;
		logic [OUT_IDX_W-1:0]     top_niche;
		logic signed [DATA_W-1:0] top_value;
		logic signed [DATA_W-1:0] top_score;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_READ,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic load_in;
		logic prep;
		logic div_step;
		logic rd_en;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic edge_bin;
		logic div_last;
		logic out_busy;
	} status_t;

endpackage

### rtl/core/eai_ram.sv
// ----------------------------------------------------------------------------
// eai_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module eai_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/eai_ctrl.sv
// ----------------------------------------------------------------------------
// eai_ctrl
// Sequencer for one offer: bin, divide unless the value lands in an edge niche, read the niche, then commit.
// ----------------------------------------------------------------------------
module eai_ctrl
	import eai_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_PREP;
				end
			end
			ST_PREP: begin
				state_next = status.edge_bin ? ST_READ : ST_DIV;
			end
			ST_DIV: begin
				if (status.div_last) begin
					state_next = ST_READ;
				end
			end
			ST_READ: begin
				state_next = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (!status.out_busy) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.load_in = in_valid;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
			end
			ST_COMMIT: begin
				cmd.commit = !status.out_busy;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

### rtl/core/eai_dpath.sv
// ----------------------------------------------------------------------------
// eai_dpath
// Binning divider, niche score store, counters, best tracking, output register.
// ----------------------------------------------------------------------------
module eai_dpath
	import eai_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  in_item_t             in_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	input  cmd_t                 cmd,
	output status_t              status,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data
);

	localparam int PROD_W = DATA_W + NICHE_W;

	logic signed [DATA_W-1:0] low_bound_q;
	logic signed [DATA_W-1:0] high_bound_q;

	logic signed [DATA_W-1:0] value_q;
	logic signed [DATA_W-1:0] score_q;
	logic signed [DATA_W:0]   span_q;
	logic signed [DATA_W:0]   offset_q;

	logic [DATA_W-1:0]  rem_q;
	logic [NICHE_W-1:0] quo_q;
	logic [DIVC_W-1:0]  div_cnt_q;

	logic [NICHES-1:0] filled_q;
	logic [DATA_W-1:0] offer_cnt_q;
	logic [DATA_W-1:0] reject_cnt_q;

	logic                     best_valid_q;
	logic [NICHE_W-1:0]       best_cell_q;
	logic signed [DATA_W-1:0] best_val_q;
	logic signed [DATA_W-1:0] best_score_q;

	logic      out_valid_q;
	out_item_t out_q;

	logic signed [DATA_W:0] span_in;
	logic signed [DATA_W:0] offset_in;
	logic                   below_range;
	logic                   above_range;
	logic [PROD_W-1:0]      dividend;
	logic [DATA_W:0]        rem_shift;
	logic [DATA_W:0]        span_mag;
	logic                   qbit;

	logic [DATA_W-1:0]        rd_score;
	logic                     acc;
	logic                     best_upd;
	logic [DATA_W-1:0]        offer_next;
	logic [DATA_W-1:0]        reject_next;
	logic [NICHE_W-1:0]       best_cell_next;
	logic signed [DATA_W-1:0] best_val_next;
	logic signed [DATA_W-1:0] best_score_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_bound_q  <= LOW_BOUND_RST;
			high_bound_q <= HIGH_BOUND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOW_BOUND:  low_bound_q  <= cfg_data;
				CFG_HIGH_BOUND: high_bound_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Range arithmetic is done one bit wider so that no difference overflows.
	assign span_in   = {high_bound_q[DATA_W-1], high_bound_q}
		- {low_bound_q[DATA_W-1], low_bound_q};
	assign offset_in = {in_data.cand_value[DATA_W-1], in_data.cand_value}
		- {low_bound_q[DATA_W-1], low_bound_q};

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			value_q  <= in_data.cand_value;
			score_q  <= in_data.cand_score;
			span_q   <= span_in;
			offset_q <= offset_in;
		end
	end

	assign below_range = span_q[DATA_W] || (span_q == '0) || offset_q[DATA_W];
	assign above_range = offset_q >= span_q;
	assign dividend    = PROD_W'(offset_q[DATA_W-1:0]) * PROD_W'(NICHES);

	// Restoring division of offset*NICHES by the span. When the offset is below
	// the span, the upper part of the dividend is already below the span, so one
	// quotient bit per cycle over the low dividend bits finishes the job.
	assign span_mag  = {1'b0, span_q[DATA_W-1:0]};
	assign rem_shift = {rem_q, quo_q[NICHE_W-1]};
	assign qbit      = rem_shift >= span_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.prep) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			rem_q <= dividend[PROD_W-1:NICHE_W];
			if (below_range) begin
				quo_q <= '0;
			end else if (above_range) begin
				quo_q <= NICHE_W'(NICHES - 1);
			end else begin
				quo_q <= dividend[NICHE_W-1:0];
			end
		end else if (cmd.div_step) begin
			rem_q <= qbit ? DATA_W'(rem_shift - span_mag) : DATA_W'(rem_shift);
			quo_q <= NICHE_W'({quo_q, qbit});
		end
	end

	// Only scores are kept per niche: a stored value is reported only while it
	// is the best, and that copy lives in the best registers.
	eai_ram #(
		.WIDTH(DATA_W),
		.DEPTH(NICHES)
	) u_score_ram (
		.clk  (clk),
		.we   (cmd.commit && acc),
		.waddr(quo_q),
		.wdata(score_q),
		.re   (cmd.rd_en),
		.raddr(quo_q),
		.rdata(rd_score)
	);

	assign acc = !filled_q[quo_q] || (score_q > $signed(rd_score));

	assign best_upd = acc && (!best_valid_q || (score_q > best_score_q)
		|| ((score_q == best_score_q) && (quo_q < best_cell_q))
		|| (quo_q == best_cell_q));

	assign offer_next      = offer_cnt_q + 1'b1;
	assign reject_next     = acc ? reject_cnt_q : reject_cnt_q + 1'b1;
	assign best_cell_next  = best_upd ? quo_q : best_cell_q;
	assign best_val_next   = best_upd ? value_q : best_val_q;
	assign best_score_next = best_upd ? score_q : best_score_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q     <= '0;
			offer_cnt_q  <= '0;
			reject_cnt_q <= '0;
			best_valid_q <= 1'b0;
			best_cell_q  <= '0;
			best_val_q   <= '0;
			best_score_q <= '0;
		end else if (cmd.commit) begin
			if (acc) begin
				filled_q[quo_q] <= 1'b1;
			end
			offer_cnt_q  <= offer_next;
			reject_cnt_q <= reject_next;
			if (best_upd) begin
				best_valid_q <= 1'b1;
			end
			best_cell_q  <= best_cell_next;
			best_val_q   <= best_val_next;
			best_score_q <= best_score_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.accepted        <= acc;
			out_q.niche_index     <= OUT_IDX_W'(quo_q);
			out_q.offers_seen     <= offer_next;
			out_q.offers_rejected <= reject_next;
			out_q.top_niche       <= OUT_IDX_W'(best_cell_next);
			out_q.top_value       <= best_val_next;
			out_q.top_score       <= best_score_next;
		end
	end

	assign status.edge_bin = below_range || above_range;
	assign status.div_last = div_cnt_q == DIVC_W'(NICHE_W - 1);
	assign status.out_busy = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### rtl/core/elite_archive_insert.sv
// A result is presented after the PREP, READ and COMMIT states when the value falls
// below or at/above the configured range or that range is empty or inverted, and
// after the DIV states of the binning divider's bit-per-cycle quotient loop as well
// otherwise; COMMIT waits while the output register is held. The next offer is taken
// in the cycle after the commit, while a finished result still waits in the output register.
// Reset marks all niches empty, clears the counters and best entry, and loads 0.0 .. 1.0.
// ----------------------------------------------------------------------------
// elite_archive_insert
// One-dimensional elite archive: bins each candidate into a niche and keeps
// the highest-scoring candidate of every niche and of the whole archive.
// ----------------------------------------------------------------------------
module elite_archive_insert
	import eai_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	cmd_t    cmd;
	status_t status;

	eai_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	eai_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the elite archive insert block. Offers go in through
// the valid/stall input channel and every result is checked field by field
// against a behavioral copy of the archive kept in this module. The run covers
// directed edge cases of the binning and replacement rules, then random offers
// over several value ranges, with random gaps and stalls on both channels and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import eai_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_GAP        = 13;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 12;
	localparam int PHASE_ITEMS    = 90;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_LOW_BOUND;
	logic [DATA_W-1:0]    cfg_data  = '0;

	// Behavioral copy of the archive.
	logic signed [DATA_W-1:0] range_lo;
	logic signed [DATA_W-1:0] range_hi;
	bit                       cell_taken [NICHES];
	logic signed [DATA_W-1:0] cell_val [NICHES];
	logic signed [DATA_W-1:0] cell_sc [NICHES];
	logic [DATA_W-1:0]        n_offers;
	logic [DATA_W-1:0]        n_rejects;
	bit                       best_ok;
	logic [NICHE_W-1:0]       best_idx;
	logic signed [DATA_W-1:0] best_v;
	logic signed [DATA_W-1:0] best_s;

	out_item_t pending_results [$];
	int        mismatches   = 0;
	int        n_ranges     = 1;
	int        stuck_cycles = 0;
	int        rx_wait      = 0;
	bit        idle_on      = 1'b1;
	logic      hold_active  = 1'b0;

	always #6 clk = ~clk;

	elite_archive_insert dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Bins one offer, applies it to the archive copy and returns the result.
	function automatic out_item_t archive_offer(in_item_t it);
		out_item_t          r;
		longint             span;
		longint             offset;
		longint             q;
		logic [NICHE_W-1:0] n;
		bit                 take;
		span   = longint'(range_hi) - longint'(range_lo);
		offset = longint'(it.cand_value) - longint'(range_lo);
		if (span <= 0 || offset < 0) begin
			q = 0;
		end else begin
			q = (offset * NICHES) / span;
			if (q > NICHES - 1)
				q = NICHES - 1;
		end
		n = q[NICHE_W-1:0];
		n_offers = n_offers + 1;
		take = !cell_taken[n] || it.cand_score > cell_sc[n];
		if (take) begin
			cell_taken[n] = 1'b1;
			cell_val[n]   = it.cand_value;
			cell_sc[n]    = it.cand_score;
			// A cell's score only rises, so a stored candidate that lands on the
			// best cell always stays the best.
			if (!best_ok || it.cand_score > best_s ||
					(it.cand_score == best_s && n < best_idx) || n == best_idx) begin
				best_ok  = 1'b1;
				best_idx = n;
				best_v   = it.cand_value;
				best_s   = it.cand_score;
			end
		end else begin
			n_rejects = n_rejects + 1;
		end
		r.accepted        = take;
		r.niche_index     = n;
		r.offers_seen     = n_offers;
		r.offers_rejected = n_rejects;
		r.top_niche       = best_idx;
		r.top_value       = best_v;
		r.top_score       = best_s;
		return r;
	endfunction

	function automatic in_item_t random_offer();
		in_item_t it;
		longint   span;
		int       pick;
		span = longint'(range_hi) - longint'(range_lo);
		pick = $urandom_range(99, 0);
		if (pick < 70 && span > 0) begin
			it.cand_value = DATA_W'(longint'(range_lo) + longint'({32'd0, $urandom}) % span);
		end else if (pick < 85) begin
			case ($urandom_range(3, 0))
				0: it.cand_value = range_lo;
				1: it.cand_value = range_lo - 1;
				2: it.cand_value = range_hi;
				default: it.cand_value = range_hi - 1;
			endcase
		end else begin
			it.cand_value = $urandom;
		end
		// A slowly rising score band keeps replacements happening late in the run.
		pick = $urandom_range(99, 0);
		if (pick < 40) begin
			it.cand_score = $urandom;
		end else if (pick < 80) begin
			it.cand_score = n_offers * 4096 - 32'd1048576 + $urandom_range(2097152, 0);
		end else begin
			case ($urandom_range(4, 0))
				0: it.cand_score = Q_MIN;
				1: it.cand_score = Q_MAX;
				2: it.cand_score = -32'sd1;
				3: it.cand_score = 32'sd0;
				default: it.cand_score = 32'sd1;
			endcase
		end
		return it;
	endfunction

	task automatic offer(in_item_t it);
		int gap;
		gap = idle_on ? $urandom_range(MAX_GAP, 0) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(archive_offer(it));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_range(logic signed [DATA_W-1:0] lo, logic signed [DATA_W-1:0] hi);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LOW_BOUND;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= CFG_HIGH_BOUND;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we   <= 1'b0;
		range_lo = lo;
		range_hi = hi;
		n_ranges++;
	endtask

	task automatic test_directed();
		// Reset range 0.0 .. 1.0: first fill, equal score, values below and above.
		offer(in_item_t'{32'sd0, 32'sd0});
		offer(in_item_t'{32'sd0, 32'sd0});
		offer(in_item_t'{32'sd100, 32'sd1});
		offer(in_item_t'{-32'sd1, 32'sd5});
		offer(in_item_t'{Q_MIN, Q_MIN});
		offer(in_item_t'{32'sd65536, Q_MIN});
		offer(in_item_t'{Q_MAX, Q_MAX});
		offer(in_item_t'{32'sd65535, Q_MAX});
		// Tie on the best score moves the best to the lower niche.
		offer(in_item_t'{32'sd1024, Q_MAX});
		offer(in_item_t'{32'sd1023, 32'sd7});
		offer(in_item_t'{32'sd2048, -32'sd3});
		offer(in_item_t'{Q_MIN, Q_MAX});
		offer(in_item_t'{32'sd64512, 32'sd100});
		// Empty range, then an inverted one: everything lands in niche 0.
		program_range(32'sd327680, 32'sd327680);
		offer(in_item_t'{Q_MAX, 32'sd3});
		offer(in_item_t'{-32'sd12345, Q_MAX});
		program_range(Q_MAX, Q_MIN);
		offer(in_item_t'{32'sd0, 32'sd9});
		// Widest range, where the top edge saturates.
		program_range(Q_MIN, Q_MAX);
		offer(in_item_t'{Q_MIN, 32'sd42});
		offer(in_item_t'{Q_MAX, 32'sd43});
		offer(in_item_t'{32'sd0, 32'sd44});
		offer(in_item_t'{-32'sd1, 32'sd45});
	endtask

	task automatic test_random_ranges();
		logic signed [DATA_W-1:0] lows  [8];
		logic signed [DATA_W-1:0] highs [8];
		lows  = '{-32'sd655360, Q_MIN, 32'sd100, Q_MIN, 32'sd458752,
			32'sd65536, 32'sd0, 32'sd0};
		highs = '{32'sd655360, Q_MAX, 32'sd164, 32'sh8000_003F, 32'sd458752,
			-32'sd65536, 32'sd0, HIGH_BOUND_RST};
		lows[6]  = $urandom;
		highs[6] = $urandom;
		for (int p = 0; p < 8; p++) begin
			program_range(lows[p], highs[p]);
			// Every other phase runs both channels without idle cycles.
			idle_on <= p[0];
			@(posedge clk);
			repeat (PHASE_ITEMS) offer(random_offer());
		end
		idle_on <= 1'b1;
	endtask

	task automatic test_backpressure();
		drain();
		// The receiver holds off while the sender keeps offering, so the block
		// fills up and has to stall its input.
		hold_active <= 1'b1;
		fork
			begin
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active <= 1'b0;
			end
		join_none
		idle_on <= 1'b0;
		@(posedge clk);
		repeat (30) offer(random_offer());
		idle_on <= 1'b1;
		// The sender pauses until every transaction has come back.
		drain();
		repeat (30) offer(random_offer());
	endtask

	task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%08h, got 0x%08h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no offer outstanding");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("accepted", want.accepted, out_data.accepted);
				check_field("niche_index", want.niche_index, out_data.niche_index);
				check_field("offers_seen", want.offers_seen, out_data.offers_seen);
				check_field("offers_rejected", want.offers_rejected, out_data.offers_rejected);
				check_field("top_niche", want.top_niche, out_data.top_niche);
				check_field("top_value", want.top_value, out_data.top_value);
				check_field("top_score", want.top_score, out_data.top_score);
			end
		end
	end

	// After each result the receiver draws how long it stalls before the next.
	always @(posedge clk) begin
		if (out_valid === 1'b1 && !out_stall)
			rx_wait = idle_on ? $urandom_range(MAX_GAP, 0) : 0;
		else if (rx_wait > 0)
			rx_wait--;
		out_stall <= hold_active || rx_wait > 0;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$error("no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		range_lo  = LOW_BOUND_RST;
		range_hi  = HIGH_BOUND_RST;
		n_offers  = '0;
		n_rejects = '0;
		best_ok   = 1'b0;
		best_idx  = '0;
		best_v    = '0;
		best_s    = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_ranges();
		test_backpressure();
		drain();
		$display("Ran %0d offers over %0d range settings: %0d stored, %0d turned away.",
			n_offers, n_ranges, n_offers - n_rejects, n_rejects);
		$display("Both channels idled 0 to %0d cycles per transaction; one %0d-cycle output hold-off.",
			MAX_GAP, HOLD_CYCLES);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
rtl/core/eai_pkg.sv
rtl/core/eai_ram.sv
rtl/core/eai_ctrl.sv
rtl/core/eai_dpath.sv
rtl/core/elite_archive_insert.sv
bench/tb_top.sv
